// File: rtl/esd_pkg.sv
// shared types and constants of the escape sequence decoder
package esd_pkg;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);
  localparam int unsigned CpW       = 21;

  typedef enum logic [1:0] {
    KIND_DATA       = 2'd0,
    KIND_END        = 2'd1,
    KIND_INVALID    = 2'd2,
    KIND_INCOMPLETE = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    OP_ONE  = 2'd0,
    OP_TWO  = 2'd1,
    OP_UTF8 = 2'd2
  } op_e;

  typedef struct packed {
    op_e            op;
    logic [7:0]     byte0;
    kind_e          kind0;
    logic [7:0]     byte1;
    kind_e          kind1;
    logic [CpW-1:0] cp;
  } job_t;

  localparam logic [7:0] CharNul    = 8'h00;
  localparam logic [7:0] CharBslash = 8'h5c;
  localparam logic [7:0] CharN      = 8'h6e;
  localparam logic [7:0] CharR      = 8'h72;
  localparam logic [7:0] CharA      = 8'h61;
  localparam logic [7:0] CharT      = 8'h74;
  localparam logic [7:0] CharB      = 8'h62;
  localparam logic [7:0] CharV      = 8'h76;
  localparam logic [7:0] CharF      = 8'h66;
  localparam logic [7:0] CharX      = 8'h78;
  localparam logic [7:0] CharLowU   = 8'h75;
  localparam logic [7:0] CharUpU    = 8'h55;

  localparam logic [7:0] CodeLf  = 8'h0a;
  localparam logic [7:0] CodeCr  = 8'h0d;
  localparam logic [7:0] CodeBel = 8'h07;
  localparam logic [7:0] CodeTab = 8'h09;
  localparam logic [7:0] CodeBs  = 8'h08;
  localparam logic [7:0] CodeVt  = 8'h0b;
  localparam logic [7:0] CodeFf  = 8'h0c;

  localparam logic [CpW-1:0] Utf8Max1 = 21'h00007f;
  localparam logic [CpW-1:0] Utf8Max2 = 21'h0007ff;
  localparam logic [CpW-1:0] Utf8Max3 = 21'h00ffff;
  localparam logic [7:0]     Lead2    = 8'hc0;
  localparam logic [7:0]     Lead3    = 8'he0;
  localparam logic [7:0]     Lead4    = 8'hf0;
  localparam logic [7:0]     Cont     = 8'h80;
  localparam logic [7:0]     ContMask = 8'h3f;

endpackage

// File: rtl/esd_in_if.sv
// input channel: one string byte per item
interface esd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// File: rtl/esd_out_if.sv
// output channel: one decoded result per item
interface esd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       last_of_run;

  modport source (output valid, output out_byte, output kind, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input kind, input last_of_run, output ready);
endinterface

// File: rtl/esd_front.sv
// front end: escape state machine that turns the input bytes into jobs
module esd_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  esd_in_if.sink           in_i,
  input  logic             full_i,
  output logic             push_o,
  output esd_pkg::job_t    job_o
);
  import esd_pkg::*;

  typedef enum logic [2:0] {
    MODE_NORMAL  = 3'd0,
    MODE_ESC     = 3'd1,
    MODE_OCT     = 3'd2,
    MODE_HEX     = 3'd3,
    MODE_DISCARD = 3'd4
  } mode_e;

  mode_e          mode_q, mode_d;
  logic [CpW-1:0] acc_q, acc_d;
  logic [3:0]     seen_q, seen_d;
  logic [3:0]     need_q, need_d;
  logic           accept;
  logic           push;
  job_t           job;
  logic [7:0]     b;
  logic           is_oct;
  logic           hex_ok;
  logic [3:0]     hex_val;
  logic [7:0]     oct_acc;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign b          = in_i.in_byte;
  assign is_oct     = (b[7:3] == 5'b00110);
  assign oct_acc    = {acc_q[4:0], b[2:0]};

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = b[3:0];
    if (b >= 8'h30 && b <= 8'h39) begin
      hex_val = b[3:0];
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      hex_val = b[3:0] + 4'd9;
    end else begin
      hex_ok  = 1'b0;
    end
  end

  always_comb begin
    mode_d    = mode_q;
    acc_d     = acc_q;
    seen_d    = seen_q;
    need_d    = need_q;
    push      = 1'b0;
    job.op    = OP_ONE;
    job.byte0 = b;
    job.kind0 = KIND_DATA;
    job.byte1 = CharNul;
    job.kind1 = KIND_END;
    job.cp    = '0;
    unique case (mode_q)
      MODE_NORMAL: begin
        if (b == CharNul) begin
          push      = 1'b1;
          job.kind0 = KIND_END;
        end else if (b == CharBslash) begin
          mode_d = MODE_ESC;
        end else begin
          push = 1'b1;
        end
      end
      MODE_ESC: begin
        mode_d = MODE_NORMAL;
        acc_d  = '0;
        seen_d = '0;
        need_d = '0;
        case (b)
          CharNul: begin
            push      = 1'b1;
            job.op    = OP_TWO;
            job.kind0 = KIND_INCOMPLETE;
          end
          CharN: begin push = 1'b1; job.byte0 = CodeLf;  end
          CharR: begin push = 1'b1; job.byte0 = CodeCr;  end
          CharA: begin push = 1'b1; job.byte0 = CodeBel; end
          CharT: begin push = 1'b1; job.byte0 = CodeTab; end
          CharB: begin push = 1'b1; job.byte0 = CodeBs;  end
          CharV: begin push = 1'b1; job.byte0 = CodeVt;  end
          CharF: begin push = 1'b1; job.byte0 = CodeFf;  end
          CharX: begin
            mode_d = MODE_HEX;
            need_d = 4'd2;
          end
          CharLowU: begin
            mode_d = MODE_HEX;
            need_d = 4'd4;
          end
          CharUpU: begin
            mode_d = MODE_HEX;
            need_d = 4'd8;
          end
          default: begin
            if (is_oct) begin
              mode_d = MODE_OCT;
              acc_d  = {{(CpW-3){1'b0}}, b[2:0]};
              seen_d = 4'd1;
            end else begin
              push = 1'b1;
            end
          end
        endcase
      end
      MODE_OCT: begin
        if (is_oct) begin
          acc_d  = {{(CpW-8){1'b0}}, oct_acc};
          seen_d = seen_q + 4'd1;
          if (seen_d >= 4'd3) begin
            push      = 1'b1;
            job.byte0 = oct_acc;
            mode_d    = MODE_NORMAL;
            acc_d     = '0;
            seen_d    = '0;
            need_d    = '0;
          end
        end else begin
          push      = 1'b1;
          job.byte0 = acc_q[7:0];
          mode_d    = MODE_NORMAL;
          acc_d     = '0;
          seen_d    = '0;
          need_d    = '0;
          if (b == CharNul) begin
            job.op = OP_TWO;
          end else if (b == CharBslash) begin
            mode_d = MODE_ESC;
          end else begin
            job.op    = OP_TWO;
            job.byte1 = b;
            job.kind1 = KIND_DATA;
          end
        end
      end
      MODE_HEX: begin
        if (b == CharNul) begin
          push      = 1'b1;
          job.op    = OP_TWO;
          job.byte0 = CharNul;
          job.kind0 = KIND_INVALID;
          mode_d    = MODE_NORMAL;
          acc_d     = '0;
          seen_d    = '0;
          need_d    = '0;
        end else if (!hex_ok) begin
          push      = 1'b1;
          job.byte0 = CharNul;
          job.kind0 = KIND_INVALID;
          mode_d    = MODE_DISCARD;
          acc_d     = '0;
          seen_d    = '0;
          need_d    = '0;
        end else begin
          acc_d  = {acc_q[CpW-5:0], hex_val};
          seen_d = seen_q + 4'd1;
          if (seen_d >= need_q) begin
            push = 1'b1;
            if (need_q == 4'd2) begin
              job.byte0 = acc_d[7:0];
            end else begin
              job.op = OP_UTF8;
              job.cp = acc_d;
            end
            mode_d = MODE_NORMAL;
            acc_d  = '0;
            seen_d = '0;
            need_d = '0;
          end
        end
      end
      MODE_DISCARD: begin
        if (b == CharNul) begin
          push      = 1'b1;
          job.kind0 = KIND_END;
          mode_d    = MODE_NORMAL;
        end
      end
      default: begin
        mode_d = MODE_NORMAL;
        acc_d  = '0;
        seen_d = '0;
        need_d = '0;
      end
    endcase
  end

  assign push_o = accept && push;
  assign job_o  = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NORMAL;
      acc_q  <= '0;
      seen_q <= '0;
      need_q <= '0;
    end else if (accept) begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      seen_q <= seen_d;
      need_q <= need_d;
    end
  end

endmodule

// File: rtl/esd_fifo.sv
// short job queue between front and back end
module esd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  esd_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output esd_pkg::job_t data_o
);
  import esd_pkg::*;

  job_t                mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_q, rd_q;
  logic [FifoCntW-1:0] cnt_q;
  logic                do_pop;

  assign full_o  = (cnt_q == FifoCntW'(FifoDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && do_pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: rtl/esd_back.sv
// back end: expands jobs into result items, utf-8 encoding, output register
module esd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  esd_pkg::job_t job_i,
  output logic          pop_o,
  esd_out_if.source     out_o
);
  import esd_pkg::*;

  logic       valid_q;
  logic [7:0] byte_q;
  kind_e      kind_q;
  logic       last_q;
  logic [1:0] idx_q, idx_d;
  logic [1:0] last_idx;
  logic [7:0] res_byte;
  kind_e      res_kind;
  logic       load;
  logic       res_last;

  always_comb begin
    last_idx = 2'd0;
    res_byte = job_i.byte0;
    res_kind = job_i.kind0;
    case (job_i.op)
      OP_ONE: begin
        last_idx = 2'd0;
      end
      OP_TWO: begin
        last_idx = 2'd1;
        if (idx_q != 2'd0) begin
          res_byte = job_i.byte1;
          res_kind = job_i.kind1;
        end
      end
      OP_UTF8: begin
        res_kind = KIND_DATA;
        if (job_i.cp <= Utf8Max1) begin
          last_idx = 2'd0;
          res_byte = {1'b0, job_i.cp[6:0]};
        end else if (job_i.cp <= Utf8Max2) begin
          last_idx = 2'd1;
          case (idx_q)
            2'd0:    res_byte = Lead2 | {3'b000, job_i.cp[10:6]};
            default: res_byte = Cont | (ContMask & {2'b00, job_i.cp[5:0]});
          endcase
        end else if (job_i.cp <= Utf8Max3) begin
          last_idx = 2'd2;
          case (idx_q)
            2'd0:    res_byte = Lead3 | {4'b0000, job_i.cp[15:12]};
            2'd1:    res_byte = Cont | (ContMask & {2'b00, job_i.cp[11:6]});
            default: res_byte = Cont | (ContMask & {2'b00, job_i.cp[5:0]});
          endcase
        end else begin
          last_idx = 2'd3;
          case (idx_q)
            2'd0:    res_byte = Lead4 | {5'b00000, job_i.cp[20:18]};
            2'd1:    res_byte = Cont | (ContMask & {2'b00, job_i.cp[17:12]});
            2'd2:    res_byte = Cont | (ContMask & {2'b00, job_i.cp[11:6]});
            default: res_byte = Cont | (ContMask & {2'b00, job_i.cp[5:0]});
          endcase
        end
      end
      default: begin
        last_idx = 2'd0;
      end
    endcase
  end

  assign res_last = (idx_q == last_idx);
  assign load     = !empty_i && (!valid_q || out_o.ready);
  assign pop_o    = load && res_last;
  assign idx_d    = res_last ? 2'd0 : idx_q + 2'd1;

  assign out_o.valid       = valid_q;
  assign out_o.out_byte    = byte_q;
  assign out_o.kind        = kind_q;
  assign out_o.last_of_run = last_q;

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= (res_kind == KIND_DATA) ? res_byte : CharNul;
      kind_q <= res_kind;
      last_q <= res_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= idx_d;
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/escape_sequence_decoder.sv
// top level of the c-style escape decoder with utf-8 output
//
// in_i takes one string byte per item, byte 0 ends the string. out_o gives
// the decoded results: data bytes, an end item per string and error items
// for bad or unfinished escapes; last_of_run marks the final result that a
// given input byte causes.
// the front end classifies each byte in the cycle it is accepted and queues
// the jobs in a four-entry queue; the back end expands each job into results,
// one result per cycle unless the receiver stalls, through a registered output.
// a result passes from its accepted input byte through the queue entry and
// then the output register to out_o.
// throughput: one input byte per cycle while each byte gives at most one
// result and the receiver is ready; a byte that gives several results holds
// the single output register for them in turn; the queue absorbs such bursts.
// when the receiver stalls, the output holds and the queue fills; in_i.ready
// drops once the queue is full.
// reset clears the escape state, the queue and the output valid flag.
module escape_sequence_decoder (
  input  logic      clk_i,
  input  logic      rst_ni,
  esd_in_if.sink    in_i,
  esd_out_if.source out_o
);
  import esd_pkg::*;

  logic push;
  logic pop;
  logic full;
  logic empty;
  job_t job_in;
  job_t job_out;

  esd_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .job_o  (job_in)
  );

  esd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (job_out)
  );

  esd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .job_i   (job_out),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
